>>> sv/descending_key_sorted_insert_table_top_macros.svh
// Assertion macros for the sorted insert table.
`ifndef DESCENDING_KEY_SORTED_INSERT_TABLE_TOP_MACROS_SVH
`define DESCENDING_KEY_SORTED_INSERT_TABLE_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DKST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
// next-cycle implication
`define DKST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define DKST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DKST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/dkst_pkg.sv
// Shared types and codes for the sorted insert table.
`default_nettype none
package dkst_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int TAG_BITS_DEF = 16;

    // sort_mode codes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_SECOND = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp_en;    // latch compare flags
        logic upd_en;    // apply insert (write or shift)
        logic strict;    // single-entry table: only a greater key goes first
        logic by_second; // compare on the second key
    } ctl_t;

endpackage
`default_nettype wire

>>> sv/descending_key_sorted_insert_table_top.sv
// Top level of the descending sorted insert table built from a chain of cells.
// A read steps through the compare and finish states, an insert through compare,
// select and finish. One item at a time: the next item is taken once the previous
// one has reached the output register; a result held by m_tready stalls the finish state.
// The compare, select and shift steps of the cell chain set the pace of each item.
// Reset (aresetn low, synchronous): table empty, sort_mode = 1, no result held.
`default_nettype none
`include "descending_key_sorted_insert_table_top_macros.svh"
module descending_key_sorted_insert_table_top #(
    parameter int CAPACITY = dkst_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = dkst_pkg::TAG_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: sort_mode
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_wr_data,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata, low bit up: key_first[31:0], key_second[63:32],
    // entry_tag[79:64], read_index[87:80]
    input  wire logic [87:0]  s_tdata,
    // s_tuser: req_type
    input  wire logic         s_tuser,
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata, low bit up: out_key_first[31:0], out_key_second[63:32],
    // out_tag[79:64], read_ok[80], insert_position[88:81],
    // insert_dropped[89], entry_count[98:90], zero pad[103:99]
    output logic [103:0]      m_tdata
);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_CMP  = 2'd1;  // cells compare / read mux
    localparam logic [1:0] ST_SEL  = 2'd2;  // chain picks the slot
    localparam logic [1:0] ST_FIN  = 2'd3;  // cells update, result out

    logic [1:0]          state_reg, state_next;
    logic [1:0]          mode_reg;
    logic                req_reg;
    logic [31:0]         k1_reg, k2_reg;
    logic [15:0]         tag_in_reg;
    logic [7:0]          ridx_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    slot_reg;
    logic [31:0]         rd_k1_reg, rd_k2_reg;
    logic [15:0]         rd_tag_reg;
    logic                rd_ok_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [103:0]        m_tdata_reg;

    logic                s_fire, out_free, fin_fire, is_insert, drop_now, do_insert;
    logic                use_second, force_end, any_back, ridx_ok;
    logic [31:0]         new_key;
    logic [TAG_BITS-1:0] new_tag;
    logic [IDX_W-1:0]    slot_enc, rd_addr;
    logic [IDX_W-1:0]    pos_out;
    dkst_pkg::ctl_t      ctl;

    logic [31:0]         k1_arr  [CAPACITY];
    logic [31:0]         k2_arr  [CAPACITY];
    logic [TAG_BITS-1:0] tag_arr [CAPACITY];
    logic [CAPACITY:0]   pre_chain;
    logic [CAPACITY-1:0] sel_vec, back_vec;

    // ---------------- handshake ----------------
    assign s_tready  = state_reg == ST_IDLE;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fin_fire  = (state_reg == ST_FIN) && out_free;
    assign is_insert = req_reg == dkst_pkg::REQ_INSERT;
    // full table or ignore mode drops the insert
    assign drop_now  = (mode_reg == dkst_pkg::MODE_IGNORE) || (count_reg >= CNT_W'(CAPACITY));
    assign do_insert = fin_fire && is_insert && !drop_now;

    // ---------------- key selection ----------------
    assign use_second = mode_reg == dkst_pkg::MODE_SECOND;
    assign new_key    = use_second ? k2_reg : k1_reg;
    assign new_tag    = TAG_BITS'(tag_in_reg);

    assign ctl.cmp_en    = (state_reg == ST_CMP) && is_insert;
    assign ctl.upd_en    = do_insert;
    // a single entry only yields the front to a strictly greater key
    assign ctl.strict    = count_reg == CNT_W'(1);
    assign ctl.by_second = use_second;

    // append mode, or a key at most the back key (two or more entries),
    // lands at the end of the table; a key at least the front key wins first
    assign any_back  = |back_vec;
    assign force_end = (mode_reg == dkst_pkg::MODE_APPEND) ||
                       ((count_reg >= CNT_W'(2)) && any_back && !pre_chain[1]);

    // ---------------- the cell chain ----------------
    // Each cell compares the stored key that the mode selects against new_key.
    assign pre_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [31:0]         prev_k1, prev_k2;
        logic [TAG_BITS-1:0] prev_tag;
        if (i == 0) begin : g_head
            assign prev_k1  = k1_reg;
            assign prev_k2  = k2_reg;
            assign prev_tag = new_tag;
        end else begin : g_link
            assign prev_k1  = k1_arr[i-1];
            assign prev_k2  = k2_arr[i-1];
            assign prev_tag = tag_arr[i-1];
        end

        dkst_cell #(
            .CAPACITY (CAPACITY),
            .TAG_BITS (TAG_BITS),
            .INDEX    (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .new_key   (new_key),
            .new_k1    (k1_reg),
            .new_k2    (k2_reg),
            .new_tag   (new_tag),
            .prev_k1   (prev_k1),
            .prev_k2   (prev_k2),
            .prev_tag  (prev_tag),
            .count     (count_reg),
            .slot      (slot_reg),
            .force_end (force_end),
            .any_le    (pre_chain[CAPACITY]),
            .pre_in    (pre_chain[i]),
            .pre_out   (pre_chain[i+1]),
            .sel       (sel_vec[i]),
            .back      (back_vec[i]),
            .k1        (k1_arr[i]),
            .k2        (k2_arr[i]),
            .tag       (tag_arr[i])
        );
    end

    // one-hot slot to index
    always_comb begin
        slot_enc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel_vec[i]) begin
                slot_enc = slot_enc | IDX_W'(i);
            end
        end
    end

    // ---------------- read port ----------------
    assign ridx_ok = (32'(ridx_reg) < 32'(count_reg)) && (32'(ridx_reg) < 32'(CAPACITY));
    assign rd_addr = IDX_W'(ridx_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CMP && !is_insert) begin
            rd_ok_reg  <= ridx_ok;
            rd_k1_reg  <= ridx_ok ? k1_arr[rd_addr] : 32'd0;
            rd_k2_reg  <= ridx_ok ? k2_arr[rd_addr] : 32'd0;
            rd_tag_reg <= ridx_ok ? 16'(tag_arr[rd_addr]) : 16'd0;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = is_insert ? ST_SEL : ST_FIN;
            end
            ST_SEL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_next    = do_insert ? count_reg + 1'b1 : count_reg;
    assign m_tvalid_next = fin_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= dkst_pkg::MODE_FIRST;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) mode_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg    <= s_tuser;
            k1_reg     <= s_tdata[31:0];
            k2_reg     <= s_tdata[63:32];
            tag_in_reg <= s_tdata[79:64];
            ridx_reg   <= s_tdata[87:80];
        end
        if (state_reg == ST_SEL) begin
            slot_reg <= slot_enc;
        end
    end

    // result register
    assign pos_out = (is_insert && !drop_now) ? slot_reg : '0;

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_tdata_reg[31:0]   <= is_insert ? 32'd0 : rd_k1_reg;
            m_tdata_reg[63:32]  <= is_insert ? 32'd0 : rd_k2_reg;
            m_tdata_reg[79:64]  <= is_insert ? 16'd0 : rd_tag_reg;
            m_tdata_reg[80]     <= !is_insert && rd_ok_reg;
            m_tdata_reg[88:81]  <= 8'(pos_out);
            m_tdata_reg[89]     <= is_insert && drop_now;
            m_tdata_reg[98:90]  <= 9'(count_next);
            m_tdata_reg[103:99] <= 5'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks ----------------
    `DKST_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `DKST_ASSERT_NXT(a_count_hold, aclk, aresetn, !do_insert, $stable(count_reg))
    `DKST_ASSERT_NXT(a_count_inc, aclk, aresetn, do_insert, count_reg == $past(count_reg) + 1'b1)
    `DKST_ASSERT_IMP(a_valid_src, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == ST_FIN)

endmodule
`default_nettype wire

>>> sv/dkst_cell.sv
// One table cell: holds an entry, compares it, shifts toward the back.
`default_nettype none
module dkst_cell #(
    parameter int CAPACITY = dkst_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = dkst_pkg::TAG_BITS_DEF,
    parameter int INDEX    = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dkst_pkg::ctl_t                ctl,
    input  wire logic [31:0]                   new_key,
    input  wire logic [31:0]                   new_k1,
    input  wire logic [31:0]                   new_k2,
    input  wire logic [TAG_BITS-1:0]           new_tag,
    input  wire logic [31:0]                   prev_k1,
    input  wire logic [31:0]                   prev_k2,
    input  wire logic [TAG_BITS-1:0]           prev_tag,
    input  wire logic [$clog2(CAPACITY+1)-1:0] count,
    input  wire logic [$clog2(CAPACITY)-1:0]   slot,
    input  wire logic                          force_end,
    input  wire logic                          any_le,
    input  wire logic                          pre_in,
    output logic                               pre_out,
    output logic                               sel,
    output logic                               back,
    output logic [31:0]                        k1,
    output logic [31:0]                        k2,
    output logic [TAG_BITS-1:0]                tag
);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [31:0]         k1_reg, k2_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                le_reg, le_next;
    logic                back_reg, back_next;
    logic                occupied, at_end, take_new, shift_in;
    logic [31:0]         cur_key;

    // stored key that the mode compares against new_key
    assign cur_key   = ctl.by_second ? k2_reg : k1_reg;

    assign occupied  = MY_CNT < count;
    assign at_end    = MY_CNT == count;
    assign le_next   = occupied && (ctl.strict ? (cur_key < new_key) : (cur_key <= new_key));
    assign back_next = ((MY_CNT + 1'b1) == count) && (new_key <= cur_key);

    assign pre_out  = pre_in | le_reg;
    assign sel      = (!force_end && le_reg && !pre_in) || (at_end && (force_end || !any_le));
    assign back     = back_reg;
    assign take_new = MY_IDX == slot;
    assign shift_in = (MY_IDX > slot) && (MY_CNT <= count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            le_reg   <= 1'b0;
            back_reg <= 1'b0;
        end else if (ctl.cmp_en) begin
            le_reg   <= le_next;
            back_reg <= back_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.upd_en) begin
            if (take_new) begin
                k1_reg  <= new_k1;
                k2_reg  <= new_k2;
                tag_reg <= new_tag;
            end else if (shift_in) begin
                k1_reg  <= prev_k1;
                k2_reg  <= prev_k2;
                tag_reg <= prev_tag;
            end
        end
    end

    assign k1  = k1_reg;
    assign k2  = k2_reg;
    assign tag = tag_reg;

endmodule
`default_nettype wire
